>>> rtl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and defaults for the sorted key/value table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Request codes carried on the input tuser field.
  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  // Action broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2
  } state_e;

  typedef struct packed {
    logic cmp_en;  // latch key compare flags
    cmd_e cmd;     // update to apply this cycle
  } cell_ctrl_t;

endpackage : skvt_pkg

`default_nettype wire

>>> rtl/skvt_cell.sv
// ----------------------------------------------------------------------------
// skvt_cell
// One slot of the sorted chain: holds a key, a value and a valid bit, compares
// against the broadcast key and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_cell #(
  parameter int unsigned KEY_WIDTH   = skvt_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire skvt_pkg::cell_ctrl_t  ctrl_i,
  input  wire  [KEY_WIDTH-1:0]       key_i,
  input  wire  [VALUE_WIDTH-1:0]     value_i,
  input  wire  [KEY_WIDTH-1:0]       left_key_i,
  input  wire  [VALUE_WIDTH-1:0]     left_value_i,
  input  wire                        left_valid_i,
  input  wire                        left_lt_i,
  input  wire  [KEY_WIDTH-1:0]       right_key_i,
  input  wire  [VALUE_WIDTH-1:0]     right_value_i,
  input  wire                        right_valid_i,
  output logic [KEY_WIDTH-1:0]       key_o,
  output logic [VALUE_WIDTH-1:0]     value_o,
  output logic                       valid_o,
  output logic                       lt_o,
  output logic                       eq_o
);
  import skvt_pkg::*;

  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   valid_q, valid_d;
  logic                   lt_q, eq_q;

  // Stored key below the request key: this slot sits before the target.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      lt_q <= valid_q && (key_q < key_i);
      eq_q <= valid_q && (key_q == key_i);
    end
  end

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    valid_d = valid_q;
    unique case (ctrl_i.cmd)
      CMD_HOLD: begin
      end
      CMD_UPDATE: begin
        if (eq_q) begin
          value_d = value_i;
        end
      end
      CMD_INSERT: begin
        valid_d = valid_q | left_valid_i;
        if (!lt_q) begin
          if (left_lt_i) begin
            key_d   = key_i;
            value_d = value_i;
          end else begin
            key_d   = left_key_i;
            value_d = left_value_i;
          end
        end
      end
      CMD_REMOVE: begin
        if (!lt_q) begin
          key_d   = right_key_i;
          value_d = right_value_i;
          valid_d = right_valid_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign valid_o = valid_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule : skvt_cell

`default_nettype wire

>>> rtl/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Sequencing: a request transfer moves the table from idle to a compare step in
//   every cell, then to an update step that applies the change and registers
//   the result once the output is free; no new request is taken until idle.
// Reset: valid bits and the pair count clear at once; keys and values are
//   left as they are, since only valid slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table #(
  parameter int unsigned CAPACITY    = skvt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH   = skvt_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = skvt_pkg::VALUE_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Request stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // [31:0] lookup_key, [63:32] write_value
  input  wire  [1:0]  s_axis_tuser,   // [1:0] req_type
  // Result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata    // [0] hit, [32:1] read_value, [33] status,
                                      // [38:34] entry_count, [39] is_empty
);
  import skvt_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // --------------------------------------------------------------------------
  // Request capture: take the fields to the table widths.
  // --------------------------------------------------------------------------
  logic [KEY_WIDTH+31:0]   key_ext;
  logic [VALUE_WIDTH+31:0] val_ext;
  logic                    in_xfer;

  assign key_ext = {{KEY_WIDTH{1'b0}}, s_axis_tdata[31:0]};
  assign val_ext = {{VALUE_WIDTH{1'b0}}, s_axis_tdata[63:32]};
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  op_e                    op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_e'(s_axis_tuser);
      key_q <= key_ext[KEY_WIDTH-1:0];
      val_q <= val_ext[VALUE_WIDTH-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: idle, compare in every cell, then apply and emit the result.
  // --------------------------------------------------------------------------
  state_e     state_q, state_d;
  cell_ctrl_t ctrl;
  logic       out_free;
  logic       apply;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    apply         = (state_q == ST_UPD) && out_free;
  end

  // --------------------------------------------------------------------------
  // Cell chain. Slot 0 holds the smallest key; inserts shift toward the top,
  // removes shift toward slot 0.
  // --------------------------------------------------------------------------
  logic [KEY_WIDTH-1:0]   cell_key [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]    valid_vec;
  logic [CAPACITY-1:0]    lt_vec;
  logic [CAPACITY-1:0]    eq_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   l_key, r_key;
    logic [VALUE_WIDTH-1:0] l_val, r_val;
    logic                   l_valid, l_lt, r_valid;

    if (i == 0) begin : g_first
      // Slot 0 sees an always-valid, always-smaller left neighbor.
      assign l_key   = key_q;
      assign l_val   = val_q;
      assign l_valid = 1'b1;
      assign l_lt    = 1'b1;
    end else begin : g_mid_l
      assign l_key   = cell_key[i-1];
      assign l_val   = cell_val[i-1];
      assign l_valid = valid_vec[i-1];
      assign l_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // The top slot empties on a remove.
      assign r_key   = cell_key[i];
      assign r_val   = cell_val[i];
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_key   = cell_key[i+1];
      assign r_val   = cell_val[i+1];
      assign r_valid = valid_vec[i+1];
    end

    skvt_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (key_q),
      .value_i       (val_q),
      .left_key_i    (l_key),
      .left_value_i  (l_val),
      .left_valid_i  (l_valid),
      .left_lt_i     (l_lt),
      .right_key_i   (r_key),
      .right_value_i (r_val),
      .right_valid_i (r_valid),
      .key_o         (cell_key[i]),
      .value_o       (cell_val[i]),
      .valid_o       (valid_vec[i]),
      .lt_o          (lt_vec[i]),
      .eq_o          (eq_vec[i])
    );
  end

  // --------------------------------------------------------------------------
  // Decide the action from the registered compare flags.
  // --------------------------------------------------------------------------
  logic [CntW-1:0]        count_q, count_d;
  logic                   found;
  logic                   full;
  logic                   reject;
  logic [VALUE_WIDTH-1:0] hit_val;
  cmd_e                   cmd;

  assign found = |eq_vec;
  assign full  = (count_q == CntW'(CAPACITY));

  // At most one slot matches, so an and-or picks its value.
  always_comb begin
    hit_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_val = hit_val | ({VALUE_WIDTH{eq_vec[i]}} & cell_val[i]);
    end
  end

  always_comb begin
    cmd     = CMD_HOLD;
    reject  = 1'b0;
    count_d = count_q;
    unique case (op_q)
      OP_SET: begin
        if (found) begin
          cmd = CMD_UPDATE;
        end else if (full) begin
          reject = 1'b1;
        end else begin
          cmd     = CMD_INSERT;
          count_d = count_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          cmd     = CMD_REMOVE;
          count_d = count_q - CntW'(1);
        end
      end
      OP_GET, OP_RSVD: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.cmp_en = (state_q == ST_CMP);
    ctrl.cmd    = apply ? cmd : CMD_HOLD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (apply) begin
      count_q <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: holds a finished transfer until the sink takes it.
  // --------------------------------------------------------------------------
  logic [VALUE_WIDTH-1:0]  rd_val;
  logic [VALUE_WIDTH+31:0] rd_ext;
  logic [CntW+4:0]         cnt_ext;
  logic [39:0]             res_d;
  logic [39:0]             res_q;
  logic                    res_valid_q;

  assign rd_val  = (op_q == OP_GET && found) ? hit_val : '0;
  assign rd_ext  = {32'b0, rd_val};
  assign cnt_ext = {5'b0, count_d};
  assign res_d   = {(count_d == '0), cnt_ext[4:0], reject, rd_ext[31:0], found};

  always_ff @(posedge clk_i) begin
    if (apply) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (apply) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("pair count above capacity");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("valid slots disagree with pair count");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> $onehot0(eq_vec))
    else $error("key matched in more than one slot");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply && reject |=> count_q == CntW'(CAPACITY) && m_axis_tvalid)
    else $error("insert rejected while table not full");

endmodule : sorted_key_value_table

`default_nettype wire

>>> tb/sorted_table_checker.sv
// ----------------------------------------------------------------------------
// sorted_table_checker
// Watches both streams of the sorted key/value table, keeps a shadow copy of
// the ordered table, predicts the result of every request transfer and checks
// each result transfer against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sorted_table_checker #(
  parameter int unsigned SLOTS = skvt_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] lookup_key, [63:32] write_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [0] hit, [32:1] read_value, [33] status,
                                      // [38:34] entry_count, [39] is_empty
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import skvt_pkg::*;

  // Same bit layout as the result tdata, hit in bit 0.
  typedef struct packed {
    logic        is_empty;
    logic [4:0]  entry_count;
    logic        status;
    logic [31:0] read_value;
    logic        hit;
  } table_result_t;

  logic [31:0]   shadow_key   [SLOTS];
  logic [31:0]   shadow_value [SLOTS];
  int unsigned   shadow_count = 0;
  table_result_t pending_results [$];

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  // Apply one request to the shadow table and return what the block must say.
  function automatic table_result_t apply_request(op_e op, logic [31:0] key,
                                                  logic [31:0] value);
    table_result_t res;
    int unsigned   pos;
    int unsigned   i;
    logic          found;
    res = '0;
    pos = 0;
    while (pos < shadow_count && shadow_key[pos] < key) pos++;
    found = (pos < shadow_count) && (shadow_key[pos] == key);
    case (op)
      OP_SET: begin
        if (found) begin
          shadow_value[pos] = value;
        end else if (shadow_count >= SLOTS) begin
          res.status = 1'b1;
        end else begin
          // open a slot at the ordered place, larger pairs move up
          for (i = shadow_count; i > pos; i--) begin
            shadow_key[i]   = shadow_key[i-1];
            shadow_value[i] = shadow_value[i-1];
          end
          shadow_key[pos]   = key;
          shadow_value[pos] = value;
          shadow_count++;
        end
      end
      OP_GET: begin
        if (found) res.read_value = shadow_value[pos];
      end
      OP_REMOVE: begin
        if (found) begin
          for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_key[i]   = shadow_key[i+1];
            shadow_value[i] = shadow_value[i+1];
          end
          shadow_count--;
        end
      end
      default: ;  // reserved code leaves the table alone
    endcase
    res.hit         = found;
    res.entry_count = 5'(shadow_count);
    res.is_empty    = (shadow_count == 0);
    return res;
  endfunction

  always @(posedge clk_i) begin
    table_result_t want;
    table_result_t got;
    if (!rst_ni) begin
      shadow_count = 0;
      pending_results.delete();
    end else begin
      // retire before predicting: a result never belongs to a same-edge request
      if (m_axis_tvalid && m_axis_tready) begin
        got = table_result_t'(m_axis_tdata);
        if (pending_results.size() == 0) begin
          $error("result transfer with no request outstanding: %h", m_axis_tdata);
          mismatch_count_o++;
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            mismatch_count_o++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
            mismatch_count_o++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_count_o++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   got.entry_count);
            mismatch_count_o++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
            mismatch_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(apply_request(op_e'(s_axis_tuser), s_axis_tdata[31:0],
                                                s_axis_tdata[63:32]));
      end
    end
    outstanding_o = pending_results.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives set, get, remove and reserved requests into the sorted key/value
// table: a directed pass over empty, full and edge-key cases, then random
// fill and drain phases over a small key pool with noise mixed in. Both
// streams idle at random and the result side holds off once for a long
// stretch. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skvt_pkg::*;

  localparam int unsigned POOL_SIZE  = 20;
  localparam int unsigned BLOCKS     = 14;
  localparam int unsigned BLOCK_LEN  = 50;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PRESS_AT   = 150;
  localparam int unsigned PRESS_LEN  = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned sent_count = 0;
  bit          no_gaps = 1'b0;
  logic [31:0] key_pool [POOL_SIZE];
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  sorted_key_value_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sorted_table_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // Called at a falling edge. An optional gap drops valid first; with no gap
  // valid stays high into the next transfer. Returns at the falling edge
  // after the transfer.
  task automatic send_request(input op_e op, input logic [31:0] key,
                              input logic [31:0] value);
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 99);
    gap  = 0;
    if (!no_gaps) begin
      if (pick >= 45 && pick < 88) gap = $urandom_range(1, 3);
      else if (pick >= 88) gap = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {value, key};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Result side: random stalls, short mostly, with quiet stretches, plus one
  // long hold while the sender keeps offering, so the block backs up.
  initial begin
    int unsigned stall;
    int unsigned calm;
    bit          pressed;
    stall   = 0;
    calm    = 0;
    pressed = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!pressed && sent_count >= PRESS_AT) begin
        pressed = 1'b1;
        stall   = PRESS_LEN;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 99) < 3) begin
          calm = $urandom_range(20, 80);
        end else if ($urandom_range(0, 99) < 30) begin
          stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 40);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either stream for too long.
  initial begin
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("sorted_key_value_table regression: fail");
    $finish;
  end

  initial begin
    int unsigned pick;
    bit          filling;
    op_e         op;
    logic [31:0] key;

    // small key pool so requests hit; it outnumbers the slots so sets get
    // rejected, and holds the extremes and adjacent keys
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = (i % 4 == 3) ? key_pool[i-1] + 1 : $urandom;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty table, edge keys, update, reserved code, remove of the
    // first pair, absent keys, then fill to capacity and push past it
    send_request(OP_GET,    32'h0000_0005, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h0000_0005, 32'h0);
    send_request(OP_SET,    32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_SET,    32'h0000_0000, 32'h0000_0000);
    send_request(OP_SET,    32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_request(OP_SET,    32'h8000_0000, 32'h1234_5678);
    send_request(OP_GET,    32'h0000_0000, 32'h0);
    send_request(OP_GET,    32'hFFFF_FFFF, 32'h0);
    send_request(OP_GET,    32'h8000_0000, 32'h0);
    send_request(OP_RSVD,   32'h0000_0000, 32'h5A5A_5A5A);
    send_request(OP_RSVD,   32'h0000_0007, 32'h0);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0);
    send_request(OP_GET,    32'h0000_0000, 32'h0);
    for (int i = 2; i < 16; i++) send_request(OP_SET, key_pool[i], $urandom);
    send_request(OP_SET,    key_pool[16], 32'hDEAD_BEEF);
    send_request(OP_SET,    key_pool[2],  32'hFFFF_FFFF);

    // random: fill and drain phases over the pool, a little noise
    for (int blk = 0; blk < BLOCKS; blk++) begin
      filling = (blk % 2 == 0) ^ ($urandom_range(0, 3) == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BLOCK_LEN; n++) begin
        if (sent_count >= PRESS_AT && sent_count < PRESS_AT + 40) no_gaps = 1'b1;
        pick = $urandom_range(0, 99);
        key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 8) begin
          op  = op_e'($urandom_range(0, 3));
          key = $urandom;
        end else if (pick < 11) begin
          op = OP_RSVD;
        end else if (pick < (filling ? 60 : 25)) begin
          op = OP_SET;
        end else if (pick < (filling ? 85 : 50)) begin
          op = OP_GET;
        end else begin
          op = OP_REMOVE;
        end
        send_request(op, key, $urandom);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain the results, then keep the clock running so that strays would show
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("sorted_key_value_table regression: pass");
    end else begin
      $display("sorted_key_value_table regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/sorted_key_value_table.sv
tb/sorted_table_checker.sv
tb/tb.sv
